// ===== hdl/olt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_pkg
// types and constants shared by the ordered list table engine
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam int unsigned OLT_DEPTH = 1024;
  localparam int unsigned OLT_AW    = $clog2(OLT_DEPTH);
  localparam int unsigned OLT_LW    = $clog2(OLT_DEPTH + 1);
  localparam int unsigned OLT_POS_W = 11;
  localparam int unsigned OLT_CW    = (OLT_LW > OLT_POS_W) ? OLT_LW : OLT_POS_W;

  typedef enum logic [2:0] {
    OP_INSERT       = 3'd0,
    OP_DELETE_AT    = 3'd1,
    OP_FIND         = 3'd2,
    OP_COUNT        = 3'd3,
    OP_DEDUPE       = 3'd4,
    OP_DELETE_RANGE = 3'd5
  } olt_op_e;

  localparam logic KIND_FIND  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DREAD,
    ST_DCMP,
    ST_FINAL
  } olt_state_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [10:0]        position;
    logic signed [31:0] value;
    logic signed [31:0] upper_bound;
  } olt_req_t;

  typedef struct packed {
    logic        answer_kind;
    logic [10:0] answer;
  } olt_res_t;

endpackage
`default_nettype wire

// ===== hdl/olt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module olt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/ordered_list_table_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_table_engine
// ordered list of signed values in one ram: insert, delete, find, count,
// dedupe and range delete, walked one entry at a time
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// request   in         start high, busy low      req_i (olt_req_t)
// result    out        result_valid_o, 1 cycle   res_o (olt_res_t)
//
// each entry visited takes a ram read, then its use; insert and delete at
// position walk only the tail. dedupe compares each entry with the kept
// ones. every one of these steps goes through the single ram read port.
// reset clears length and control; the ram needs no clearing.
// results cannot be stalled; busy stays high until the operation is done.
// ----------------------------------------------------------------------------
module ordered_list_table_engine
  import olt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire olt_req_t req_i,
  output logic          result_valid_o,
  output olt_res_t      res_o
);

  olt_state_e state_q, state_d;
  olt_req_t   req_q, req_d;
  logic [OLT_CW-1:0] len_q, len_d, j_q, j_d, k_q, k_d, t_q, t_d;
  logic [31:0] cur_q, cur_d;
  logic        out_valid_q, out_valid_d;
  olt_res_t    res_q, res_d;

  logic              we;
  logic [OLT_AW-1:0] waddr, raddr;
  logic [31:0]       wdata, rdata;

  logic [OLT_CW-1:0] pos_in, pos_c;
  logic              accept, op_ok, loop_more, in_rng;

  olt_ram #(.WIDTH(32), .DEPTH(OLT_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign pos_in = OLT_CW'(req_i.position);
  assign pos_c  = OLT_CW'(req_q.position);
  assign in_rng = ($signed(rdata) >= req_q.value) && ($signed(rdata) <= req_q.upper_bound);

  always_comb begin
    unique case (req_i.operation)
      OP_INSERT:    op_ok = (len_q < OLT_CW'(OLT_DEPTH)) && (pos_in != '0)
                            && (pos_in <= len_q + OLT_CW'(1));
      OP_DELETE_AT: op_ok = (pos_in != '0) && (pos_in <= len_q);
      OP_FIND, OP_COUNT, OP_DEDUPE, OP_DELETE_RANGE: op_ok = 1'b1;
      default:      op_ok = 1'b0;
    endcase
  end

  always_comb begin
    if (req_q.operation == OP_INSERT) begin
      loop_more = (j_q >= pos_c);
    end else begin
      loop_more = (j_q < len_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && op_ok) state_d = ST_READ;
      end
      ST_READ: begin
        if (loop_more) begin
          state_d = ST_EXEC;
        end else if (req_q.operation == OP_INSERT) begin
          state_d = ST_FINAL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EXEC: begin
        priority if (req_q.operation == OP_FIND && rdata == req_q.value) begin
          state_d = ST_IDLE;
        end else if (req_q.operation == OP_DEDUPE && k_q != '0) begin
          state_d = ST_DREAD;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_DREAD: state_d = ST_DCMP;
      ST_DCMP: begin
        if (rdata == cur_q || t_q + OLT_CW'(1) == k_q) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_DREAD;
        end
      end
      ST_FINAL: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and ram access
  always_comb begin
    req_d       = req_q;
    len_d       = len_q;
    j_d         = j_q;
    k_d         = k_q;
    t_d         = t_q;
    cur_d       = cur_q;
    out_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = j_q[OLT_AW-1:0];
    wdata       = rdata;
    raddr       = j_q[OLT_AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d = req_i;
          k_d   = '0;
          if (req_i.operation == OP_INSERT) begin
            j_d = len_q;
          end else if (req_i.operation == OP_DELETE_AT) begin
            j_d = pos_in;
          end else begin
            j_d = '0;
          end
        end
      end
      ST_READ: begin
        if (req_q.operation == OP_INSERT) begin
          raddr = OLT_AW'(j_q - OLT_CW'(1));
        end
        if (!loop_more) begin
          unique case (req_q.operation)
            OP_DELETE_AT: len_d = len_q - OLT_CW'(1);
            OP_FIND: begin
              out_valid_d       = 1'b1;
              res_d.answer_kind = KIND_FIND;
              res_d.answer      = '0;
            end
            OP_COUNT: begin
              out_valid_d       = 1'b1;
              res_d.answer_kind = KIND_COUNT;
              res_d.answer      = k_q[10:0];
            end
            OP_DEDUPE, OP_DELETE_RANGE: len_d = k_q;
            default: ;
          endcase
        end
      end
      ST_EXEC: begin
        unique case (req_q.operation)
          OP_INSERT: begin
            we  = 1'b1;
            j_d = j_q - OLT_CW'(1);
          end
          OP_DELETE_AT: begin
            we    = 1'b1;
            waddr = OLT_AW'(j_q - OLT_CW'(1));
            j_d   = j_q + OLT_CW'(1);
          end
          OP_FIND: begin
            j_d = j_q + OLT_CW'(1);
            if (rdata == req_q.value) begin
              out_valid_d       = 1'b1;
              res_d.answer_kind = KIND_FIND;
              res_d.answer      = 11'(j_q + OLT_CW'(1));
            end
          end
          OP_COUNT: begin
            j_d = j_q + OLT_CW'(1);
            if (in_rng) k_d = k_q + OLT_CW'(1);
          end
          OP_DELETE_RANGE: begin
            j_d = j_q + OLT_CW'(1);
            if (!in_rng) begin
              we    = 1'b1;
              waddr = k_q[OLT_AW-1:0];
              k_d   = k_q + OLT_CW'(1);
            end
          end
          OP_DEDUPE: begin
            cur_d = rdata;
            t_d   = '0;
            // first entry is always kept
            if (k_q == '0) begin
              we    = 1'b1;
              waddr = '0;
              k_d   = OLT_CW'(1);
              j_d   = j_q + OLT_CW'(1);
            end
          end
          default: ;
        endcase
      end
      ST_DREAD: raddr = t_q[OLT_AW-1:0];
      ST_DCMP: begin
        if (rdata == cur_q) begin
          j_d = j_q + OLT_CW'(1);
        end else if (t_q + OLT_CW'(1) == k_q) begin
          we    = 1'b1;
          waddr = k_q[OLT_AW-1:0];
          wdata = cur_q;
          k_d   = k_q + OLT_CW'(1);
          j_d   = j_q + OLT_CW'(1);
        end else begin
          t_d = t_q + OLT_CW'(1);
        end
      end
      ST_FINAL: begin
        we    = 1'b1;
        waddr = OLT_AW'(pos_c - OLT_CW'(1));
        wdata = req_q.value;
        len_d = len_q + OLT_CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    j_q   <= j_d;
    k_q   <= k_d;
    t_q   <= t_d;
    cur_q <= cur_d;
    res_q <= res_d;
  end

  assign result_valid_o = out_valid_q;
  assign res_o          = res_q;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= OLT_CW'(OLT_DEPTH))
    else $error("list length above depth");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_EXEC || state_q == ST_DCMP || state_q == ST_FINAL))
    else $error("ram write in a read state");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result held longer than one cycle");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_d |-> (req_q.operation == OP_FIND || req_q.operation == OP_COUNT))
    else $error("result from an operation that gives none");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_ordered_list_table_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_table_engine
// request-level check of the ordered list table engine: a list model in the
// bench tracks every accepted request, and find and count answers are
// compared in order; the list is kept short except for one long pass
// ----------------------------------------------------------------------------
module tb_ordered_list_table_engine;
  import olt_pkg::*;

  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SOFT_LEN = 48;
  localparam int unsigned RAND_ITEMS = 250;
  localparam int unsigned FILL_LEN = 200;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    olt_req_t req;
    bit       drain;
  } pending_req_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  olt_req_t req_i;
  logic     result_valid_o;
  olt_res_t res_o;

  pending_req_t      pending_q[$];
  olt_res_t          answers_due[$];
  logic signed [31:0] list_model[$];
  logic signed [31:0] gen_list[$];
  int unsigned       errors;
  int unsigned       cycles;
  int unsigned       gap_left;
  bit                no_idle;

  ordered_list_table_engine uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // applies one request to a list, returns the answer of find and count
  task automatic apply_list_op(ref logic signed [31:0] lst[$], input olt_req_t r,
                               output bit has_answer, output olt_res_t answer);
    int unsigned len;
    int unsigned k;
    bit seen;
    logic signed [31:0] kept[$];
    len = lst.size();
    k = 0;
    has_answer = 1'b0;
    answer = '0;
    case (r.operation)
      OP_INSERT: begin
        if (len < OLT_DEPTH && r.position >= 1 && r.position <= len + 1)
          lst.insert(r.position - 1, r.value);
      end
      OP_DELETE_AT: begin
        if (r.position >= 1 && r.position <= len)
          lst.delete(r.position - 1);
      end
      OP_FIND: begin
        for (int j = 0; j < len; j++) begin
          if (lst[j] == r.value) begin
            k = j + 1;
            break;
          end
        end
        has_answer = 1'b1;
        answer.answer_kind = KIND_FIND;
        answer.answer = k[10:0];
      end
      OP_COUNT: begin
        foreach (lst[j])
          if (lst[j] >= r.value && lst[j] <= r.upper_bound) k++;
        has_answer = 1'b1;
        answer.answer_kind = KIND_COUNT;
        answer.answer = k[10:0];
      end
      OP_DEDUPE: begin
        foreach (lst[j]) begin
          seen = 1'b0;
          foreach (kept[t])
            if (kept[t] == lst[j]) seen = 1'b1;
          if (!seen) kept.push_back(lst[j]);
        end
        lst = kept;
      end
      OP_DELETE_RANGE: begin
        foreach (lst[j])
          if (!(lst[j] >= r.value && lst[j] <= r.upper_bound)) kept.push_back(lst[j]);
        lst = kept;
      end
      default: begin
      end
    endcase
  endtask

  // adds a request to the stimulus and tracks the list length it leaves
  task automatic queue_req(input logic [2:0] op, input logic [10:0] pos,
                           input logic signed [31:0] val, input logic signed [31:0] hi,
                           input bit drain = 1'b0);
    pending_req_t p;
    bit dummy_has;
    olt_res_t dummy_res;
    p.req.operation = op;
    p.req.position = pos;
    p.req.value = val;
    p.req.upper_bound = hi;
    p.drain = drain;
    pending_q.push_back(p);
    apply_list_op(gen_list, p.req, dummy_has, dummy_res);
  endtask

  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $signed($urandom_range(0, 8)) - 4;
    if (sel == 6) return VAL_MIN;
    if (sel == 7) return VAL_MAX;
    return $urandom();
  endfunction

  function automatic int unsigned pick_gap();
    if (no_idle || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit has_answer;
    olt_res_t answer;
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
      gap_left <= 0;
      no_idle <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_list_op(list_model, req_i, has_answer, answer);
        if (has_answer) answers_due.push_back(answer);
      end
      if ($urandom_range(0, 199) == 0) no_idle <= ~no_idle;
      if (start && busy) begin
        // hold the request until accepted
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   (!pending_q[0].drain || answers_due.size() == 0)) begin
        start <= 1'b1;
        req_i <= pending_q[0].req;
        pending_q.pop_front();
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    olt_res_t want;
    if (rst_ni && result_valid_o) begin
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("unexpected answer kind %0b value %0d",
                                  res_o.answer_kind, res_o.answer));
      end else begin
        want = answers_due.pop_front();
        if (res_o.answer_kind !== want.answer_kind)
          report_mismatch($sformatf("answer_kind %0b, want %0b",
                                    res_o.answer_kind, want.answer_kind));
        if (res_o.answer !== want.answer)
          report_mismatch($sformatf("answer %0d, want %0d", res_o.answer, want.answer));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned sel;
    int unsigned len;
    logic signed [31:0] lo;
    errors = 0;
    cycles = 0;
    rst_ni = 1'b0;

    // directed: empty list, extremes, invalid positions, unused codes
    queue_req(OP_FIND, 11'd1, VAL_MIN, 0);
    queue_req(OP_INSERT, 11'd1, VAL_MIN, 0);
    queue_req(OP_INSERT, 11'd2, VAL_MAX, 0);
    queue_req(OP_INSERT, 11'd0, 32'sd7, 0);
    queue_req(OP_INSERT, 11'd5, 32'sd7, 0);
    queue_req(OP_INSERT, 11'd3, 32'sd0, 0);
    queue_req(OP_INSERT, 11'd1, VAL_MAX, 0);
    queue_req(OP_FIND, 11'd0, VAL_MAX, 0);
    queue_req(OP_FIND, 11'd2047, 32'sd9, 0);
    queue_req(OP_COUNT, 11'd0, VAL_MIN, VAL_MAX);
    queue_req(OP_COUNT, 11'd0, 32'sd5, -32'sd5);
    queue_req(OP_DELETE_RANGE, 11'd0, 32'sd5, -32'sd5, 1'b1);
    queue_req(OP_DELETE_AT, 11'd0, 0, 0);
    queue_req(OP_DELETE_AT, 11'd2047, 0, 0);
    queue_req(OP_UNUSED_6, 11'd1, VAL_MIN, VAL_MAX);
    queue_req(OP_UNUSED_7, 11'd1, VAL_MIN, VAL_MAX);
    queue_req(OP_DELETE_AT, 11'd4, 0, 0);
    queue_req(OP_DEDUPE, 11'd0, 0, 0);
    queue_req(OP_COUNT, 11'd0, VAL_MIN, VAL_MAX);
    queue_req(OP_DELETE_RANGE, 11'd0, -32'sd1, 32'sd1);
    queue_req(OP_FIND, 11'd0, 32'sd0, 0);
    queue_req(OP_DELETE_AT, 11'd1, 0, 0);
    queue_req(OP_COUNT, 11'd0, VAL_MIN, VAL_MAX);

    // random: mostly valid positions on a short list, some noise
    for (int i = 0; i < RAND_ITEMS; i++) begin
      len = gen_list.size();
      sel = $urandom_range(0, 99);
      lo = pick_value();
      if (len > SOFT_LEN) begin
        queue_req(OP_DELETE_RANGE, 11'($urandom()), lo, lo + $signed($urandom_range(0, 6)));
        if (gen_list.size() > SOFT_LEN) queue_req(OP_DELETE_AT, 11'd1, 0, 0);
      end else if (sel < 35) begin
        queue_req(OP_INSERT, 11'($urandom_range(1, len + 1)), lo, $urandom());
      end else if (sel < 45) begin
        queue_req(OP_DELETE_AT, 11'($urandom_range(1, len > 0 ? len : 1)), $urandom(),
                  $urandom());
      end else if (sel < 60) begin
        queue_req(OP_FIND, 11'($urandom()), lo, $urandom());
      end else if (sel < 75) begin
        queue_req(OP_COUNT, 11'($urandom()), lo,
                  $urandom_range(0, 3) == 0 ? pick_value() : lo + $signed($urandom_range(0, 5)));
      end else if (sel < 80) begin
        queue_req(OP_DEDUPE, 11'($urandom()), $urandom(), $urandom());
      end else if (sel < 85) begin
        queue_req(OP_DELETE_RANGE, 11'($urandom()), lo,
                  $urandom_range(0, 3) == 0 ? pick_value() : lo + $signed($urandom_range(0, 2)));
      end else if (sel < 95) begin
        queue_req($urandom_range(0, 1) ? OP_INSERT : OP_DELETE_AT, 11'($urandom()), lo,
                  $urandom());
      end else begin
        queue_req($urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7, 11'($urandom()),
                  $urandom(), $urandom(), 1'($urandom_range(0, 1)));
      end
    end

    // long list: fill, out-of-range positions, walks over every entry
    queue_req(OP_DELETE_RANGE, 11'd0, VAL_MIN, VAL_MAX, 1'b1);
    for (int i = 0; i < FILL_LEN; i++)
      queue_req(OP_INSERT, 11'(i + 1), $signed(i) - 100, 0);
    queue_req(OP_INSERT, 11'd1, 32'sd77, 0);
    queue_req(OP_INSERT, 11'd1024, 32'sd77, 0);
    queue_req(OP_FIND, 11'd0, 32'sd50, 0);
    queue_req(OP_COUNT, 11'd0, VAL_MIN, VAL_MAX);
    queue_req(OP_DELETE_AT, 11'd1024, 0, 0);
    queue_req(OP_INSERT, 11'd1, 32'sd600, 0);
    queue_req(OP_FIND, 11'd0, 32'sd50, 0);
    queue_req(OP_COUNT, 11'd0, -32'sd10, 32'sd10);
    queue_req(OP_DELETE_RANGE, 11'd0, VAL_MIN, VAL_MAX);
    queue_req(OP_COUNT, 11'd0, VAL_MIN, VAL_MAX);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !start && answers_due.size() == 0);
    @(posedge clk_i);
    wait (!busy);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
